FILE: hw/rtl/fse_pkg.sv
// Fourier surface evaluator: shared constants, types and the sine table builder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fse_pkg;

	localparam int MAX_POLOIDAL     = 8;
	localparam int MAX_TOROIDAL     = 8;
	localparam int SINE_TABLE_DEPTH = 1024;

	localparam int SLOT_COUNT = 2 * MAX_TOROIDAL + 1;
	localparam int ROW_COUNT  = MAX_POLOIDAL * SLOT_COUNT;
	localparam int ROW_W      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int COEF_W     = 24;
	localparam int LANE_COUNT = 6;
	localparam int LANE_W     = 3;
	localparam int ROW_DATA_W = LANE_COUNT * COEF_W;
	localparam int AXES       = 3;

	localparam int SIN_IDX_W  = $clog2(SINE_TABLE_DEPTH);
	localparam int TRIG_W     = 17;
	localparam int PHASE_W    = 16;

	localparam int FP_W       = 7;
	localparam int MODES_W    = 4;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 2;

	localparam int MP_W  = $clog2(MAX_POLOIDAL + 1);
	localparam int NT_W  = $clog2(MAX_TOROIDAL + 2);
	localparam int N_W   = NT_W + 1;
	localparam int NN_W  = $clog2(MAX_TOROIDAL * ((1 << FP_W) - 1) + 2) + 1;
	localparam int W_W   = (NN_W > MP_W + 1) ? NN_W : MP_W + 1;

	localparam int PROD_W = COEF_W + TRIG_W;
	localparam int SD_W   = PROD_W + 1;
	localparam int TERM_W = SD_W + W_W;
	localparam int ACC_W  = 64;
	localparam int OUT_W  = 48;

	// function codes
	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_POS    = 2'd1;
	localparam logic [1:0] FUNC_DPHI   = 2'd2;
	localparam logic [1:0] FUNC_DTHETA = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_PERIODS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLOIDAL      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOROIDAL      = 2'd2;

	// output scale factors, Q29
	localparam logic [31:0] K_ONE    = 32'h2000_0000;
	localparam logic [31:0] K_TWO_PI = 32'hC90F_DAA2;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Taylor term divisors (2k)(2k+1) as ceil(2^42/d); exact for dividends below 2^34
	localparam longint unsigned TAYLOR_RCP [6] = '{
		((64'd1 << 42) + 64'd5) / 64'd6,
		((64'd1 << 42) + 64'd19) / 64'd20,
		((64'd1 << 42) + 64'd41) / 64'd42,
		((64'd1 << 42) + 64'd71) / 64'd72,
		((64'd1 << 42) + 64'd109) / 64'd110,
		((64'd1 << 42) + 64'd155) / 64'd156
	};

	typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH];

	typedef struct packed {
		logic                  valid;
		logic                  use_c;
		logic                  use_s;
		logic signed [W_W-1:0] weight;
	} term_ctl_t;

	// quarter-wave sine, Q1.15, integer Taylor series through x^13
	function automatic sine_rom_t sine_build();
		sine_rom_t    tab;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned v;
		longint          sum;
		logic [127:0]    prod;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			x   = (longint'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
			x2  = (x * x) >> 30;
			t   = x;
			sum = longint'(x);
			for (int k = 1; k <= 6; k++) begin
				prod = 128'((t * x2) >> 30) * 128'(TAYLOR_RCP[k-1]);
				t    = prod[105:42];
				if (k % 2 == 1) begin
					sum = sum - longint'(t);
				end else begin
					sum = sum + longint'(t);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
			if (v > 32767) begin
				v = 32767;
			end
			tab[i] = v[15:0];
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fse_if.sv
// Request and response channel interfaces of the Fourier surface evaluator.
// Depends on fse_pkg.
`default_nettype none

interface fse_req_if;
	import fse_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic [1:0]          coord;
	logic                is_sine;
	logic [2:0]          mode_m;
	logic [4:0]          mode_n_slot;
	logic signed [23:0]  coeff_value;
	logic [15:0]         phi_phase;
	logic [15:0]         theta_phase;

	modport source (output valid, func, coord, is_sine, mode_m, mode_n_slot, coeff_value,
		phi_phase, theta_phase, input ready);
	modport sink (input valid, func, coord, is_sine, mode_m, mode_n_slot, coeff_value,
		phi_phase, theta_phase, output ready);
endinterface

interface fse_rsp_if;
	import fse_pkg::*;

	logic                valid;
	logic                ready;
	logic signed [47:0]  x_value;
	logic signed [47:0]  y_value;
	logic signed [47:0]  z_value;
	logic                saturated;

	modport source (output valid, x_value, y_value, z_value, saturated, input ready);
	modport sink (input valid, x_value, y_value, z_value, saturated, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fourier_surface_evaluator.sv
// Top level of the Fourier surface evaluator: request decode, term sequencer,
// output scaling. Depends on fse_pkg, fse_if, fse_coef_mem, fse_sine_rom, fse_mac.
`default_nettype none

// Stores cos/sin Fourier coefficients (Q4.20) of x, y, z per poloidal mode m and
// toroidal index n, and sums the double Fourier series at a point given as phi and
// theta phases (Q0.16 turns). Requests are taken only while the sequencer is idle.
// A load request writes one coefficient and returns nothing. An evaluate
// request walks the (m, n) grid one term per cycle, all three axes together,
// reading one coefficient row and two sine-table entries per term, a pace set
// by the single read port of the coefficient store. The result (Q28.20,
// clipped with a saturated flag) sits in an output register, so a new request
// may be taken while it waits. No clearing pass after reset: coefficient rows
// carry valid bits and read as zero until first written.
module fourier_surface_evaluator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	fse_req_if.sink                                req,
	fse_rsp_if.source                              rsp,
	input  wire logic                              cfg_we,
	input  wire logic [fse_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fse_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import fse_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [65:0] OUT_MAX = 66'h7FFF_FFFF_FFFF;

	// configuration
	logic [FP_W-1:0]    fp_q;
	logic [MODES_W-1:0] pol_q;
	logic [MODES_W-1:0] tor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q  <= FP_W'(1);
			pol_q <= MODES_W'(8);
			tor_q <= MODES_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIELD_PERIODS: fp_q  <= cfg_data[FP_W-1:0];
				CFG_POLOIDAL:      pol_q <= cfg_data[MODES_W-1:0];
				CFG_TOROIDAL:      tor_q <= cfg_data[MODES_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer state
	logic [2:0]              state_q;
	logic [1:0]              func_q;
	logic [PHASE_W-1:0]      phi_q, theta_q;
	logic [MP_W-1:0]         mp_q, m_q;
	logic [NT_W-1:0]         nt_q;
	logic signed [N_W-1:0]   n_q;
	logic signed [NN_W-1:0]  nn_q, nn_start_q;
	logic [PHASE_W-1:0]      mth_q;
	logic [1:0]              axis_q;
	logic                    half_q;

	// pipeline s1/s2
	term_ctl_t               ctl_s1, ctl_s2;
	logic [PHASE_W-1:0]      phase_s1;
	logic [ROW_W-1:0]        row_s1;

	// scaling
	logic [63:0]             hi_q, lo_q;
	logic                    neg_q;
	logic [OUT_W-1:0]        res_q [AXES];
	logic                    sat_q;

	// output register
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] x_q, y_q, z_q;
	logic                    out_sat_q;

	logic accept, is_load, load_ok, start_eval;
	logic [MP_W-1:0] mp_new;
	logic [NT_W-1:0] nt_new;
	logic [NN_W-1:0] nt_fp;
	logic [31:0]     nnphi;
	logic [15:0]     nn16;
	logic [ROW_W-1:0] load_row;
	logic            mac_busy;
	logic signed [TRIG_W-1:0] sin_s2, cos_s2;
	logic [ROW_DATA_W-1:0]    coef_s2;
	logic signed [ACC_W-1:0]  acc [AXES];
	logic            last_n, last_m;
	logic [63:0]     mag;
	logic [31:0]     k_sel;
	logic [65:0]     t_sum;
	logic [65:0]     t_rnd;
	logic            sat_now;
	logic [OUT_W-1:0] res_now;

	assign req.ready  = (state_q == ST_IDLE);
	assign accept     = req.valid & req.ready;
	assign is_load    = (req.func == FUNC_LOAD);
	assign load_ok    = (req.coord <= 2'd2) && (32'(req.mode_m) < MAX_POLOIDAL)
		&& (32'(req.mode_n_slot) < SLOT_COUNT);
	assign start_eval = accept & ~is_load;
	assign load_row   = ROW_W'(32'(req.mode_m) * SLOT_COUNT + 32'(req.mode_n_slot));

	// clamp the mode counts to what the store holds
	assign mp_new = (32'(pol_q) > MAX_POLOIDAL) ? MP_W'(MAX_POLOIDAL) : MP_W'(pol_q);
	assign nt_new = (32'(tor_q) > MAX_TOROIDAL) ? NT_W'(MAX_TOROIDAL) : NT_W'(tor_q);
	assign nt_fp  = NN_W'(nt_new) * NN_W'(fp_q);

	assign last_n = (n_q == $signed({1'b0, nt_q}));
	assign last_m = (m_q == mp_q - MP_W'(1));

	// phase a = m*theta - n*N*phi, wrapping in 16 bits
	assign nn16  = 16'(nn_q);
	assign nnphi = {16'b0, nn16} * {16'b0, phi_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			axis_q  <= '0;
			half_q  <= 1'b0;
			m_q     <= '0;
			n_q     <= '0;
			mp_q    <= '0;
			nt_q    <= '0;
		end else begin
			ctl_s1.valid <= 1'b0;
			ctl_s2       <= ctl_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (start_eval) begin
						mp_q   <= mp_new;
						nt_q   <= nt_new;
						m_q    <= '0;
						n_q    <= -$signed({1'b0, nt_new});
						axis_q <= '0;
						half_q <= 1'b0;
						state_q <= (mp_new == '0) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					ctl_s1.valid  <= 1'b1;
					ctl_s1.use_c  <= !(m_q == '0 && n_q < 0);
					ctl_s1.use_s  <= !(m_q == '0 && n_q <= 0);
					case (func_q)
						FUNC_DPHI:   ctl_s1.weight <= W_W'(nn_q);
						FUNC_DTHETA: ctl_s1.weight <= -$signed(W_W'({1'b0, m_q}));
						default:     ctl_s1.weight <= W_W'(1);
					endcase
					if (last_n) begin
						n_q <= -$signed({1'b0, nt_q});
						if (last_m) begin
							state_q <= ST_DRAIN;
						end else begin
							m_q <= m_q + MP_W'(1);
						end
					end else begin
						n_q <= n_q + N_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!ctl_s1.valid && !ctl_s2.valid && !mac_busy) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					half_q <= ~half_q;
					if (half_q) begin
						axis_q <= axis_q + 2'd1;
						if (axis_q == 2'(AXES - 1)) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		if (start_eval) begin
			func_q     <= req.func;
			phi_q      <= req.phi_phase;
			theta_q    <= req.theta_phase;
			mth_q      <= '0;
			nn_start_q <= -$signed(nt_fp);
			nn_q       <= -$signed(nt_fp);
		end else if (state_q == ST_RUN) begin
			if (last_n) begin
				nn_q  <= nn_start_q;
				mth_q <= mth_q + theta_q;
			end else begin
				nn_q <= nn_q + $signed(NN_W'(fp_q));
			end
		end
		phase_s1 <= mth_q - nnphi[15:0];
		// slot = n + MAX_TOROIDAL, formed in 32 bits so n = +MAX_TOROIDAL cannot wrap
		row_s1   <= ROW_W'(32'(m_q) * SLOT_COUNT + 32'(n_q) + MAX_TOROIDAL);
	end

	fse_coef_mem u_coef_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept & is_load & load_ok),
		.wr_row  (load_row),
		.wr_lane ({req.coord, req.is_sine}),
		.wr_data (req.coeff_value),
		.rd_row  (row_s1),
		.rd_data (coef_s2)
	);

	// cosine is the sine a quarter turn ahead
	fse_sine_rom u_sine_rom (
		.clk     (clk),
		.phase_a (phase_s1),
		.phase_b (phase_s1 + 16'h4000),
		.sin_a   (sin_s2),
		.sin_b   (cos_s2)
	);

	fse_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (start_eval),
		.is_pos  (func_q == FUNC_POS),
		.ctl_s2  (ctl_s2),
		.sin_s2  (sin_s2),
		.cos_s2  (cos_s2),
		.coef_s2 (coef_s2),
		.acc     (acc),
		.busy    (mac_busy)
	);

	// scaling: |S|*k split into two 32x32 partial products, then round and clip
	assign mag   = acc[axis_q][ACC_W-1] ? 64'(-acc[axis_q]) : 64'(acc[axis_q]);
	assign k_sel = (func_q == FUNC_POS) ? K_ONE : K_TWO_PI;
	assign t_sum = 66'(hi_q) + 66'(lo_q[63:32]) + 66'd2048;
	assign t_rnd = t_sum >> 12;

	always_comb begin
		sat_now = 1'b0;
		res_now = t_rnd[OUT_W-1:0];
		if (!neg_q) begin
			if (t_rnd > OUT_MAX) begin
				sat_now = 1'b1;
				res_now = OUT_MAX[OUT_W-1:0];
			end
		end else begin
			if (t_rnd > OUT_MAX + 66'd1) begin
				sat_now = 1'b1;
				res_now = -OUT_W'(OUT_MAX + 66'd1);
			end else begin
				res_now = -t_rnd[OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_eval) begin
			sat_q <= 1'b0;
		end else if (state_q == ST_SCALE) begin
			if (!half_q) begin
				hi_q  <= 64'(mag[63:32]) * 64'(k_sel);
				lo_q  <= 64'(mag[31:0]) * 64'(k_sel);
				neg_q <= acc[axis_q][ACC_W-1];
			end else begin
				res_q[axis_q] <= res_now;
				sat_q         <= sat_q | sat_now;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || rsp.ready)) begin
			x_q       <= $signed(res_q[0]);
			y_q       <= $signed(res_q[1]);
			z_q       <= $signed(res_q[2]);
			out_sat_q <= sat_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.x_value   = x_q;
	assign rsp.y_value   = y_q;
	assign rsp.z_value   = z_q;
	assign rsp.saturated = out_sat_q;

`ifndef SYNTHESIS
	a_scale_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCALE |-> !ctl_s1.valid && !ctl_s2.valid && !mac_busy)
		else $error("scaling started with terms in flight");
	a_run_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> m_q < mp_q && n_q <= $signed({1'b0, nt_q}))
		else $error("term counters out of range");
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_load |-> !mac_busy && !ctl_s1.valid && !ctl_s2.valid)
		else $error("coefficient write while a sum is running");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/fse_coef_mem.sv
// Coefficient store: one row per (m, slot), six 24-bit lanes (x/y/z cos/sin).
// Depends on fse_pkg. Rows never written read as zero via per-row valid bits.
`default_nettype none

module fse_coef_mem (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [fse_pkg::ROW_W-1:0]     wr_row,
	input  wire logic [fse_pkg::LANE_W-1:0]    wr_lane,
	input  wire logic [fse_pkg::COEF_W-1:0]    wr_data,
	input  wire logic [fse_pkg::ROW_W-1:0]     rd_row,
	output      logic [fse_pkg::ROW_DATA_W-1:0] rd_data
);
	import fse_pkg::*;

	logic [ROW_DATA_W-1:0] mem [ROW_COUNT];
	logic [ROW_COUNT-1:0]  row_valid_q;
	logic [ROW_DATA_W-1:0] rd_data_q;
	logic                  rd_ok_q;
	logic [ROW_DATA_W-1:0] fresh_row;

	// first write to a row zero-fills the other lanes
	always_comb begin
		fresh_row = '0;
		fresh_row[wr_lane*COEF_W +: COEF_W] = wr_data;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (row_valid_q[wr_row]) begin
				mem[wr_row][wr_lane*COEF_W +: COEF_W] <= wr_data;
			end else begin
				mem[wr_row] <= fresh_row;
			end
		end
		rd_data_q <= mem[rd_row];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_ok_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_row] <= 1'b1;
			end
			rd_ok_q <= row_valid_q[rd_row];
		end
	end

	assign rd_data = rd_ok_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/fse_sine_rom.sv
// Dual-read quarter-wave sine ROM with registered output and quadrant fold.
// Depends on fse_pkg (table builder).
`default_nettype none

module fse_sine_rom (
	input  wire logic                              clk,
	input  wire logic [fse_pkg::PHASE_W-1:0]       phase_a,
	input  wire logic [fse_pkg::PHASE_W-1:0]       phase_b,
	output      logic signed [fse_pkg::TRIG_W-1:0] sin_a,
	output      logic signed [fse_pkg::TRIG_W-1:0] sin_b
);
	import fse_pkg::*;

	localparam sine_rom_t ROM = sine_build();
	localparam int IDX_PROD_W = 14 + SIN_IDX_W + 1;

	function automatic logic [SIN_IDX_W-1:0] fold_idx(input logic [PHASE_W-1:0] ph);
		logic [13:0]           p;
		logic [IDX_PROD_W-1:0] prod;
		logic [SIN_IDX_W:0]    full;
		p    = ph[14] ? (14'h3FFF - ph[13:0]) : ph[13:0];
		prod = IDX_PROD_W'(p) * IDX_PROD_W'(SINE_TABLE_DEPTH);
		full = prod[IDX_PROD_W-1:14];
		if (full >= (SIN_IDX_W+1)'(SINE_TABLE_DEPTH)) begin
			full = (SIN_IDX_W+1)'(SINE_TABLE_DEPTH - 1);
		end
		return full[SIN_IDX_W-1:0];
	endfunction

	logic [15:0] raw_a_q, raw_b_q;
	logic        neg_a_q, neg_b_q;

	always_ff @(posedge clk) begin
		raw_a_q <= ROM[fold_idx(phase_a)];
		raw_b_q <= ROM[fold_idx(phase_b)];
		neg_a_q <= phase_a[15];
		neg_b_q <= phase_b[15];
	end

	assign sin_a = neg_a_q ? -$signed({1'b0, raw_a_q}) : $signed({1'b0, raw_a_q});
	assign sin_b = neg_b_q ? -$signed({1'b0, raw_b_q}) : $signed({1'b0, raw_b_q});

endmodule

`default_nettype wire

FILE: hw/rtl/fse_mac.sv
// Three-axis term multiplier and accumulator (stages s2..s4).
// Depends on fse_pkg.
`default_nettype none

module fse_mac (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               clear,
	input  wire logic                               is_pos,
	input  wire fse_pkg::term_ctl_t                 ctl_s2,
	input  wire logic signed [fse_pkg::TRIG_W-1:0]  sin_s2,
	input  wire logic signed [fse_pkg::TRIG_W-1:0]  cos_s2,
	input  wire logic [fse_pkg::ROW_DATA_W-1:0]     coef_s2,
	output      logic signed [fse_pkg::ACC_W-1:0]   acc [fse_pkg::AXES],
	output      logic                               busy
);
	import fse_pkg::*;

	logic signed [TRIG_W-1:0] op_c, op_s;
	logic signed [PROD_W-1:0] a_s3 [AXES];
	logic signed [PROD_W-1:0] b_s3 [AXES];
	logic signed [W_W-1:0]    weight_s3;
	logic signed [TERM_W-1:0] term_s4 [AXES];
	logic                     v_s3, v_s4;
	logic signed [ACC_W-1:0]  acc_q [AXES];

	// position: cc*cos + sc*sin; derivatives: cc*sin - sc*cos times weight
	assign op_c = is_pos ? cos_s2 : sin_s2;
	assign op_s = is_pos ? sin_s2 : cos_s2;

	always_ff @(posedge clk) begin
		for (int d = 0; d < AXES; d++) begin
			a_s3[d] <= ctl_s2.use_c ?
				$signed(coef_s2[(2*d)*COEF_W +: COEF_W]) * op_c : $signed(PROD_W'(0));
			b_s3[d] <= ctl_s2.use_s ?
				$signed(coef_s2[(2*d+1)*COEF_W +: COEF_W]) * op_s : $signed(PROD_W'(0));
			term_s4[d] <= (is_pos ? (SD_W'(a_s3[d]) + SD_W'(b_s3[d]))
				: (SD_W'(a_s3[d]) - SD_W'(b_s3[d]))) * weight_s3;
		end
		weight_s3 <= ctl_s2.weight;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int d = 0; d < AXES; d++) begin
				acc_q[d] <= '0;
			end
		end else begin
			v_s3 <= ctl_s2.valid;
			v_s4 <= v_s3;
			for (int d = 0; d < AXES; d++) begin
				if (clear) begin
					acc_q[d] <= '0;
				end else if (v_s4) begin
					acc_q[d] <= acc_q[d] + ACC_W'(term_s4[d]);
				end
			end
		end
	end

	assign acc  = acc_q;
	assign busy = v_s3 | v_s4;

endmodule

`default_nettype wire

FILE: tb/sv/fse_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Fourier surface evaluator: watches the request, response and
// register ports, predicts each evaluation and compares it. Depends on fse_pkg, fse_if.
`default_nettype none

module fse_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	fse_req_if                                  req,
	fse_rsp_if                                  rsp,
	input  wire logic                           cfg_we,
	input  wire logic [fse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fse_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                  errors,
	output int                                  pending
);
	import fse_pkg::*;

	localparam int COEF_DEPTH = 6 * MAX_POLOIDAL * SLOT_COUNT;
	localparam longint OUT_LIMIT = 64'sd140737488355327;

	typedef struct packed {
		logic signed [47:0] x;
		logic signed [47:0] y;
		logic signed [47:0] z;
		logic               sat;
	} surf_point_t;

	logic signed [23:0] coef_mem [COEF_DEPTH];
	logic [15:0]        quarter_sine [SINE_TABLE_DEPTH];
	logic [6:0]         n_periods;
	logic [3:0]         m_used;
	logic [3:0]         n_used;
	surf_point_t        points_due [$];
	int                 shown;

	assign pending = points_due.size();

	// quarter-wave table, Q1.15, from a Taylor series in Q30
	initial begin
		longint unsigned x, x2, t, v;
		longint          acc;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			x   = (longint'(i) * 64'd1686629713) / SINE_TABLE_DEPTH;
			x2  = (x * x) >> 30;
			t   = x;
			acc = longint'(x);
			for (int k = 1; k <= 6; k++) begin
				t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					acc = acc - longint'(t);
				end else begin
					acc = acc + longint'(t);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			v = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
			if (v > 32767) begin
				v = 32767;
			end
			quarter_sine[i] = v[15:0];
		end
	end

	function automatic longint sine_of(input logic [15:0] ph);
		logic [13:0] p;
		longint      idx;
		longint      v;
		p = ph[13:0];
		if (ph[14]) begin
			p = ~p;
		end
		idx = (longint'(p) * SINE_TABLE_DEPTH) >> 14;
		if (idx >= SINE_TABLE_DEPTH) begin
			idx = SINE_TABLE_DEPTH - 1;
		end
		v = longint'(quarter_sine[idx]);
		return ph[15] ? -v : v;
	endfunction

	// |s|*k/2^44 rounded half away from zero, clipped to 48 bits
	function automatic logic [47:0] scale_clip(input longint s, input longint unsigned k,
			inout logic sat);
		logic [127:0]    prod;
		longint unsigned mag;
		longint unsigned t;
		mag  = (s < 0) ? longint'(-s) : longint'(s);
		prod = 128'(mag) * 128'(k);
		t    = ((prod >> 32) + 2048) >> 12;
		if (s >= 0) begin
			if (t > OUT_LIMIT) begin
				sat = 1'b1;
				t   = OUT_LIMIT;
			end
			return t[47:0];
		end
		if (t > OUT_LIMIT + 1) begin
			sat = 1'b1;
			t   = OUT_LIMIT + 1;
		end
		return 48'(-longint'(t));
	endfunction

	function automatic surf_point_t surface_eval(input logic [1:0] f, input logic [15:0] phi,
			input logic [15:0] theta);
		surf_point_t r;
		longint      sums [3];
		int          mp, nt, nn, base;
		logic [15:0] ph;
		longint      sv, cv, cc, sc;
		mp = (m_used > MAX_POLOIDAL) ? MAX_POLOIDAL : m_used;
		nt = (n_used > MAX_TOROIDAL) ? MAX_TOROIDAL : n_used;
		sums = '{0, 0, 0};
		for (int m = 0; m < mp; m++) begin
			for (int n = -nt; n <= nt; n++) begin
				nn = n * int'(n_periods);
				ph = 16'(m * int'(theta) - nn * int'(phi));
				sv = sine_of(ph);
				cv = sine_of(ph + 16'h4000);
				for (int d = 0; d < 3; d++) begin
					base = (d * 2 * MAX_POLOIDAL + m) * SLOT_COUNT + n + MAX_TOROIDAL;
					// m=0 cosine with n<0 and m=0 sine with n<=0 never count
					cc = (m == 0 && n < 0) ? 0 : longint'(coef_mem[base]);
					sc = (m == 0 && n <= 0) ? 0 :
						longint'(coef_mem[base + MAX_POLOIDAL * SLOT_COUNT]);
					case (f)
						FUNC_POS:  sums[d] += cc * cv + sc * sv;
						FUNC_DPHI: sums[d] += longint'(nn) * (cc * sv - sc * cv);
						default:   sums[d] += longint'(m) * (sc * cv - cc * sv);
					endcase
				end
			end
		end
		r.sat = 1'b0;
		r.x = scale_clip(sums[0], (f == FUNC_POS) ? K_ONE : K_TWO_PI, r.sat);
		r.y = scale_clip(sums[1], (f == FUNC_POS) ? K_ONE : K_TWO_PI, r.sat);
		r.z = scale_clip(sums[2], (f == FUNC_POS) ? K_ONE : K_TWO_PI, r.sat);
		return r;
	endfunction

	task automatic compare_point(input surf_point_t got);
		surf_point_t want;
		if (points_due.size() == 0) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("%0t: unexpected response x=%0d y=%0d z=%0d sat=%0b", $realtime,
					got.x, got.y, got.z, got.sat);
			end
			return;
		end
		want = points_due.pop_front();
		if (want != got) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("%0t: mismatch exp x=%0d y=%0d z=%0d sat=%0b", $realtime,
					want.x, want.y, want.z, want.sat);
				$display("%0t:          got x=%0d y=%0d z=%0d sat=%0b", $realtime,
					got.x, got.y, got.z, got.sat);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (coef_mem[i]) coef_mem[i] = '0;
			n_periods = 7'd1;
			m_used    = 4'd8;
			n_used    = 4'd8;
			points_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIELD_PERIODS: n_periods = cfg_data[6:0];
					CFG_POLOIDAL:      m_used    = cfg_data[3:0];
					CFG_TOROIDAL:      n_used    = cfg_data[3:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				if (req.func == FUNC_LOAD) begin
					if (req.coord <= 2 && req.mode_m < MAX_POLOIDAL &&
							req.mode_n_slot < SLOT_COUNT)
						coef_mem[((req.coord * 2 + req.is_sine) * MAX_POLOIDAL + req.mode_m)
							* SLOT_COUNT + req.mode_n_slot] = req.coeff_value;
				end else begin
					points_due.push_back(surface_eval(req.func, req.phi_phase,
						req.theta_phase));
				end
			end
			if (rsp.valid && rsp.ready)
				compare_point('{rsp.x_value, rsp.y_value, rsp.z_value, rsp.saturated});
		end
	end

	initial begin
		errors = 0;
		shown  = 0;
	end
endmodule

`default_nettype wire

FILE: tb/sv/tb_fourier_surface_evaluator.sv
`timescale 1ns / 1ps
// Top of the Fourier surface evaluator bench: clock, reset, request and register
// stimulus, response back-pressure and the verdict. Depends on fse_pkg, fse_if, fse_checker.
`default_nettype none

module tb_fourier_surface_evaluator;
	import fse_pkg::*;

	typedef struct packed {
		logic [1:0]         func;
		logic [1:0]         coord;
		logic               is_sine;
		logic [2:0]         mode_m;
		logic [4:0]         mode_n_slot;
		logic signed [23:0] coeff_value;
		logic [15:0]        phi_phase;
		logic [15:0]        theta_phase;
	} surf_req_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    pending;

	// idle percentages, changed per phase by the stimulus process
	int snd_idle_pct;
	int rcv_idle_pct;
	// one long response hold-off, asked for by the stimulus, timed by the receiver
	bit hold_ask;
	bit hold_done;

	fse_req_if req ();
	fse_rsp_if rsp ();

	fourier_surface_evaluator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fse_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: random ready, plus one long stall so the block backs up and
	// holds off new requests while the sender keeps offering.
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_ask && !hold_done) begin
				hold_done = 1'b1;
				rsp.ready <= 1'b0;
				repeat (1500) @(posedge clk);
			end else begin
				rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Offer one request; returns at the edge where it was taken. Ready is looked
	// at on the falling edge so the decision never races the block's update.
	task automatic send_req(input surf_req_t r);
		bit taken;
		if ($urandom_range(99) < snd_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req.valid       <= 1'b1;
		req.func        <= r.func;
		req.coord       <= r.coord;
		req.is_sine     <= r.is_sine;
		req.mode_m      <= r.mode_m;
		req.mode_n_slot <= r.mode_n_slot;
		req.coeff_value <= r.coeff_value;
		req.phi_phase   <= r.phi_phase;
		req.theta_phase <= r.theta_phase;
		do begin
			@(negedge clk);
			taken = req.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Stop offering and let every outstanding evaluation come back; loads give no
	// response, so an extra margin covers one full grid walk still in flight.
	task automatic drain();
		req.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// drives one write and holds it for one edge; the caller drops the enable
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
	endtask

	task automatic set_geometry(input int fp, input int pm, input int tm);
		drain();
		write_reg(CFG_FIELD_PERIODS, fp);
		write_reg(CFG_POLOIDAL, pm);
		write_reg(CFG_TOROIDAL, tm);
		cfg_we <= 1'b0;
	endtask

	function automatic surf_req_t load_req(input int c, input int s, input int m,
			input int slot, input int v);
		surf_req_t r;
		r = surf_req_t'({$urandom, $urandom, $urandom});
		r.func        = FUNC_LOAD;
		r.coord       = 2'(c);
		r.is_sine     = 1'(s);
		r.mode_m      = 3'(m);
		r.mode_n_slot = 5'(slot);
		r.coeff_value = 24'(v);
		return r;
	endfunction

	function automatic surf_req_t eval_req(input logic [1:0] f, input int phi, input int theta);
		surf_req_t r;
		r = surf_req_t'({$urandom, $urandom, $urandom});
		r.func        = f;
		r.phi_phase   = 16'(phi);
		r.theta_phase = 16'(theta);
		return r;
	endfunction

	// Half loads, mostly well-formed inside the grid, some with bad axis or slot,
	// coefficients biased toward the extremes now and then; the rest are evaluations.
	function automatic surf_req_t random_req();
		surf_req_t r;
		int        pick;
		r    = surf_req_t'({$urandom, $urandom, $urandom});
		pick = $urandom_range(99);
		if (pick < 50) begin
			r.func  = FUNC_LOAD;
			r.coord = ($urandom_range(9) == 0) ? 2'(3) : 2'($urandom_range(2));
			if ($urandom_range(9) != 0) begin
				r.mode_n_slot = 5'($urandom_range(SLOT_COUNT - 1));
			end
			case ($urandom_range(5))
				0: r.coeff_value = 24'sh7FFFFF;
				1: r.coeff_value = 24'sh800000;
				default: ;
			endcase
		end else begin
			r.func = 2'($urandom_range(1, 3));
		end
		return r;
	endfunction

	initial begin
		surf_req_t r;
		int        fp_set [6] = '{64, 0, 127, 3, 1, 17};
		int        pm_set [6] = '{8, 1, 15, 0, 4, 8};
		int        tm_set [6] = '{8, 0, 15, 5, 2, 8};

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		req.valid       = 1'b0;
		req.func        = FUNC_LOAD;
		req.coord       = '0;
		req.is_sine     = 1'b0;
		req.mode_m      = '0;
		req.mode_n_slot = '0;
		req.coeff_value = '0;
		req.phi_phase   = '0;
		req.theta_phase = '0;
		snd_idle_pct    = 0;
		rcv_idle_pct    = 0;
		hold_ask        = 1'b0;
		hold_done       = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: evaluate an empty store, then load extremes, including the
		// skipped m=0 entries and out-of-range addresses, and hit every function.
		send_req(eval_req(FUNC_POS, 0, 0));
		send_req(load_req(0, 0, 0, 8, 24'sh7FFFFF));
		send_req(load_req(1, 1, 7, 16, 24'sh800000));
		send_req(load_req(2, 0, 3, 0, 24'sh800000));
		send_req(load_req(0, 0, 0, 0, 24'sh7FFFFF));   // m=0 cos, n<0: never summed
		send_req(load_req(1, 1, 0, 8, 24'sh7FFFFF));   // m=0 sin, n=0: never summed
		send_req(load_req(2, 1, 0, 9, 24'sh123456));
		send_req(load_req(3, 1, 5, 4, 24'sh7FFFFF));   // bad axis: dropped
		send_req(load_req(0, 1, 2, 17, 24'sh7FFFFF));  // slot past grid: dropped
		send_req(load_req(1, 0, 2, 31, 24'sh800000));
		send_req(load_req(2, 1, 7, 1, 24'sh000001));
		send_req(eval_req(FUNC_POS, 0, 0));
		send_req(eval_req(FUNC_POS, 16'hFFFF, 16'hFFFF));
		send_req(eval_req(FUNC_DPHI, 16'h4000, 16'h8000));
		send_req(eval_req(FUNC_DTHETA, 16'hC000, 16'h0001));
		send_req(eval_req(FUNC_DPHI, 16'hFFFF, 0));
		send_req(eval_req(FUNC_DTHETA, 0, 16'hFFFF));
		send_req(eval_req(FUNC_POS, 16'h2AAA, 16'h5555));

		// Random phases, each under its own geometry; first two lean on the
		// result side, next two on the request side, last two run flat out.
		for (int ph = 0; ph < 6; ph++) begin
			set_geometry(fp_set[ph], pm_set[ph], tm_set[ph]);
			snd_idle_pct = (ph < 2) ? 17 : (ph < 4) ? 62 : 0;
			rcv_idle_pct = (ph < 2) ? 62 : (ph < 4) ? 17 : 0;
			for (int i = 0; i < 250; i++) begin
				if (ph == 0 && i == 100) begin
					hold_ask = 1'b1;
				end
				if (ph == 3 && i == 125) begin
					// full pause until every evaluation has come back
					req.valid <= 1'b0;
					while (pending != 0) @(posedge clk);
					@(posedge clk);
				end
				r = random_req();
				send_req(r);
			end
		end

		drain();
		if (errors == 0) begin
			$display("tb_fourier_surface_evaluator: done, clean");
		end else begin
			$display("tb_fourier_surface_evaluator: done, errors");
		end
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#60_000_000;
		$display("tb_fourier_surface_evaluator: done, errors");
		$finish;
	end
endmodule

`default_nettype wire
